// ===== hdl/fahq_pkg.sv =====
// package for the four-ary max-heap queue core
// entry record type, command and status codes; no dependencies
package fahq_pkg;

   typedef enum logic [1:0] {
      CMD_PUSH  = 2'd0,
      CMD_POP   = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RSVD  = 2'd3
   } status_type;

   typedef struct packed {
      logic signed [16:0] back_link;
      logic [15:0]        dfa_state;
      logic [7:0]         symbol;
      logic [31:0]        weight_scale;
      logic [31:0]        hit_count;
      logic [63:0]        prio;
      logic [31:0]        node_link;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

// ===== hdl/fahq_if.sv =====
// valid/ready channel interfaces for the four-ary max-heap queue core
// depends on nothing
interface fahq_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         cmd;
   logic signed [16:0] back_link;
   logic [15:0]        dfa_state;
   logic [7:0]         symbol;
   logic [31:0]        weight_scale;
   logic [31:0]        hit_count;
   logic [31:0]        node_link;
   modport source (output valid, cmd, back_link, dfa_state, symbol, weight_scale,
                   hit_count, node_link, input ready);
   modport sink (input valid, cmd, back_link, dfa_state, symbol, weight_scale,
                 hit_count, node_link, output ready);
endinterface

interface fahq_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic signed [16:0] out_back_link;
   logic [15:0]        out_dfa_state;
   logic [7:0]         out_symbol;
   logic [31:0]        out_weight_scale;
   logic [31:0]        out_hit_count;
   logic [31:0]        out_node_link;
   logic [10:0]        occupancy;
   modport source (output valid, status, out_back_link, out_dfa_state, out_symbol,
                   out_weight_scale, out_hit_count, out_node_link, occupancy,
                   input ready);
   modport sink (input valid, status, out_back_link, out_dfa_state, out_symbol,
                 out_weight_scale, out_hit_count, out_node_link, occupancy,
                 output ready);
endinterface

interface fahq_csr_if;
   logic        valid;
   logic        ready;
   logic [10:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// ===== hdl/fahq_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module fahq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== hdl/four_ary_max_heap_queue_core.sv =====
// four-ary max-heap queue core: one transaction in flight, exactly one result per transaction
// push: priority = hit_count * weight_scale, then the entry sifts up toward the root
// pop: the root is returned, the last entry moves to the root and sifts down over up to 4 children
// clear, rejected push, empty pop and unused command go straight to the result
// the next request is taken only after the result has been taken
// sync reset empties the queue, capacity 1024; ram not cleared; uses fahq_pkg, fahq_if, fahq_ram
module four_ary_max_heap_queue_core import fahq_pkg::*; #(
   parameter int HEAP_DEPTH = 1024
) (
   input logic       clock,
   input logic       reset,
   fahq_req_if.sink  req,
   fahq_rsp_if.source rsp,
   fahq_csr_if.sink  csr
);
   localparam int AW = $clog2(HEAP_DEPTH);
   localparam int CW = AW + 1;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_MUL   = 9'b000000010,
      S_UPRD  = 9'b000000100,
      S_UPCMP = 9'b000001000,
      S_POP0  = 9'b000010000,
      S_POP1  = 9'b000100000,
      S_DNRD  = 9'b001000000,
      S_DNCMP = 9'b010000000,
      S_RESP  = 9'b100000000
   } state_type;

   state_type      state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [10:0]    cap_ff;
   logic [AW-1:0]  idx_ff, idx_in;
   logic [AW-1:0]  last_ff, last_in;
   entry_type      ent_ff, ent_in;     // entry being placed
   entry_type      top_ff, top_in;     // popped root
   logic [2:0]     rdc_ff, rdc_in;     // child reads issued
   logic [2:0]     cmpc_ff, cmpc_in;   // children compared
   logic [2:0]     nch_ff, nch_in;     // children of this node
   logic [AW-1:0]  best_ff, best_in;
   entry_type      bent_ff, bent_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [1:0]     status_ff, status_in;
   logic           popout_ff, popout_in;

   logic           we;
   logic [AW-1:0]  wa, ra, ra_ff;
   entry_type      wd, rd;

   fahq_ram #(.WIDTH(ENTRY_W), .DEPTH(HEAP_DEPTH)) u_ram (
      .clock(clock), .wr_en(we), .wr_addr(wa), .wr_data(wd),
      .rd_addr(ra), .rd_data(rd));

   logic [31:0]   cap_use;
   logic [CW:0]   first_w;
   logic [CW:0]   span;
   logic [AW-1:0] up_idx;

   always_comb begin
      cap_use = (32'(cap_ff) > 32'(HEAP_DEPTH)) ? 32'(HEAP_DEPTH) : 32'(cap_ff);
      up_idx  = AW'((idx_ff - AW'(1)) >> 2);
      first_w = {idx_ff, 2'b00} + (CW+1)'(1);
      span    = (CW+1)'(last_ff) - first_w;
   end

   assign req.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign csr.ready = 1'b1;

   always_comb begin
      state_in = state_ff; count_in = count_ff; idx_in = idx_ff; last_in = last_ff;
      ent_in = ent_ff; top_in = top_ff; rdc_in = rdc_ff; cmpc_in = cmpc_ff;
      nch_in = nch_ff; best_in = best_ff; bent_in = bent_ff;
      rsp_valid_in = rsp_valid_ff; status_in = status_ff; popout_in = popout_ff;
      we = 1'b0; wa = idx_ff; wd = ent_ff; ra = ra_ff;
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req.valid && req.ready) begin
               status_in = ST_OK;
               popout_in = 1'b0;
               ent_in.back_link    = req.back_link;
               ent_in.dfa_state    = req.dfa_state;
               ent_in.symbol       = req.symbol;
               ent_in.weight_scale = req.weight_scale;
               ent_in.hit_count    = req.hit_count;
               ent_in.node_link    = req.node_link;
               ent_in.prio         = '0;
               case (cmd_type'(req.cmd))
                  CMD_PUSH: begin
                     if (32'(count_ff) >= cap_use) begin
                        status_in = ST_FULL;
                        state_in = S_RESP;
                     end else begin
                        idx_in = AW'(count_ff);
                        count_in = count_ff + CW'(1);
                        state_in = S_MUL;
                     end
                  end
                  CMD_POP: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                        state_in = S_RESP;
                     end else begin
                        count_in = count_ff - CW'(1);
                        last_in = AW'(count_ff - CW'(1));
                        ra = '0;
                        popout_in = 1'b1;
                        state_in = S_POP0;
                     end
                  end
                  CMD_CLEAR: begin
                     count_in = '0;
                     state_in = S_RESP;
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_MUL: begin
            ent_in.prio = 64'(ent_ff.hit_count) * 64'(ent_ff.weight_scale);
            if (idx_ff == '0) begin
               state_in = S_RESP;
               we = 1'b1; wd = ent_in;
            end else begin
               ra = up_idx;
               state_in = S_UPCMP;
            end
         end
         S_UPRD: begin
            if (idx_ff == '0) begin
               // climbed to the root
               we = 1'b1;
               state_in = S_RESP;
            end else begin
               ra = up_idx;
               state_in = S_UPCMP;
            end
         end
         S_UPCMP: begin
            we = 1'b1;
            if (rd.prio >= ent_ff.prio) begin
               state_in = S_RESP;
            end else begin
               wd = rd;
               idx_in = ra_ff;
               state_in = S_UPRD;
            end
         end
         S_POP0: begin
            // root is on rd; fetch the last entry
            top_in = rd;
            if (last_ff == '0) begin
               state_in = S_RESP;
            end else begin
               ra = last_ff;
               state_in = S_POP1;
            end
         end
         S_POP1: begin
            ent_in = rd;
            idx_in = '0;
            state_in = S_DNRD;
         end
         S_DNRD: begin
            if (first_w >= (CW+1)'(last_ff)) begin
               we = 1'b1;
               state_in = S_RESP;
            end else begin
               nch_in = (span >= (CW+1)'(4)) ? 3'd4 : 3'(span);
               ra = AW'(first_w);
               rdc_in = 3'd1;
               cmpc_in = 3'd0;
               state_in = S_DNCMP;
            end
         end
         S_DNCMP: begin
            if (rdc_ff < nch_ff) begin
               ra = ra_ff + AW'(1);
               rdc_in = rdc_ff + 3'd1;
            end
            // first strictly largest child wins
            if (cmpc_ff == '0 || rd.prio > bent_ff.prio) begin
               bent_in = rd;
               best_in = ra_ff;
            end
            cmpc_in = cmpc_ff + 3'd1;
            if (cmpc_ff + 3'd1 == nch_ff) begin
               we = 1'b1;
               if (bent_in.prio <= ent_ff.prio) begin
                  state_in = S_RESP;
               end else begin
                  wd = bent_in;
                  idx_in = best_in;
                  state_in = S_DNRD;
               end
            end
         end
         S_RESP: begin
            nch_in = '0; cmpc_in = '0; rdc_in = '0;
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         cap_ff <= 11'(1024);
         rsp_valid_ff <= 1'b0;
         nch_ff <= '0; cmpc_ff <= '0; rdc_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         nch_ff <= nch_in; cmpc_ff <= cmpc_in; rdc_ff <= rdc_in;
         if (csr.valid) begin
            cap_ff <= csr.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in; last_ff <= last_in; ent_ff <= ent_in; top_ff <= top_in;
      best_ff <= best_in; bent_ff <= bent_in; status_ff <= status_in;
      popout_ff <= popout_in; ra_ff <= ra;
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.status           = status_ff;
   assign rsp.out_back_link    = popout_ff ? top_ff.back_link : '0;
   assign rsp.out_dfa_state    = popout_ff ? top_ff.dfa_state : '0;
   assign rsp.out_symbol       = popout_ff ? top_ff.symbol : '0;
   assign rsp.out_weight_scale = popout_ff ? top_ff.weight_scale : '0;
   assign rsp.out_hit_count    = popout_ff ? top_ff.hit_count : '0;
   assign rsp.out_node_link    = popout_ff ? top_ff.node_link : '0;
   assign rsp.occupancy        = 11'(count_ff);
endmodule

// ===== bench/four_ary_max_heap_queue_core_tb.sv =====
// testbench for the four-ary max-heap queue core: directed and random push/pop/clear
// transactions, with a heap-keeping scoreboard; uses fahq_pkg, fahq_if and the core
module four_ary_max_heap_queue_core_tb;
   import fahq_pkg::*;

   localparam int DEPTH = 1024;

   typedef struct {
      logic [16:0] back_link;
      logic [15:0] dfa_state;
      logic [7:0]  symbol;
      logic [31:0] weight_scale;
      logic [31:0] hit_count;
      logic [63:0] prio;
      logic [31:0] node_link;
   } slot_type;

   typedef struct packed {
      status_type  status;
      logic [16:0] back_link;
      logic [15:0] dfa_state;
      logic [7:0]  symbol;
      logic [31:0] weight_scale;
      logic [31:0] hit_count;
      logic [31:0] node_link;
      logic [10:0] occupancy;
   } answer_type;

   class heap_scoreboard;
      slot_type    heap_mem[DEPTH];
      int unsigned fill;
      int unsigned cap_limit;
      answer_type  pending[$];
      int          mismatches;

      function new();
         fill = 0;
         cap_limit = 1024;
         mismatches = 0;
      endfunction

      function void set_capacity(int unsigned v);
         cap_limit = v;
      endfunction

      function int unsigned held();
         return fill;
      endfunction

      function void note_request(cmd_type c, logic [16:0] bl, logic [15:0] ds, logic [7:0] sy,
                                 logic [31:0] sc, logic [31:0] hc, logic [31:0] nl);
         answer_type a;
         slot_type   e, mv, top;
         int unsigned i, up, first, best, stop, cap;
         logic [63:0] bp;
         a = '{status: ST_OK, default: '0};
         case (c)
            CMD_PUSH: begin
               cap = (cap_limit > DEPTH) ? DEPTH : cap_limit;
               if (fill >= cap) begin
                  a.status = ST_FULL;
               end else begin
                  e = '{bl, ds, sy, sc, hc, 64'(hc) * 64'(sc), nl};
                  i = fill;
                  fill++;
                  while (i > 0) begin
                     up = (i - 1) >> 2;
                     if (heap_mem[up].prio >= e.prio) break;
                     heap_mem[i] = heap_mem[up];
                     i = up;
                  end
                  heap_mem[i] = e;
               end
            end
            CMD_POP: begin
               if (fill == 0) begin
                  a.status = ST_EMPTY;
               end else begin
                  top = heap_mem[0];
                  fill--;
                  if (fill != 0) begin
                     mv = heap_mem[fill];
                     i = 0;
                     forever begin
                        first = 4 * i + 1;
                        if (first >= fill) break;
                        best = first;
                        bp = heap_mem[first].prio;
                        stop = (first + 4 < fill) ? first + 4 : fill;
                        for (int k = first + 1; k < stop; k++)
                           if (heap_mem[k].prio > bp) begin
                              best = k;
                              bp = heap_mem[k].prio;
                           end
                        if (bp <= mv.prio) break;
                        heap_mem[i] = heap_mem[best];
                        i = best;
                     end
                     heap_mem[i] = mv;
                  end
                  a.back_link = top.back_link;
                  a.dfa_state = top.dfa_state;
                  a.symbol = top.symbol;
                  a.weight_scale = top.weight_scale;
                  a.hit_count = top.hit_count;
                  a.node_link = top.node_link;
               end
            end
            CMD_CLEAR: fill = 0;
            default: ;
         endcase
         a.occupancy = 11'(fill);
         pending.push_back(a);
      endfunction

      function void check_response(answer_type got);
         answer_type w;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response status=%0d", got.status);
            return;
         end
         w = pending.pop_front();
         if (got !== w) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected %p actual %p", w, got);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   fahq_req_if req ();
   fahq_rsp_if rsp ();
   fahq_csr_if csr ();

   four_ary_max_heap_queue_core dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp),
                                     .csr(csr));

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   heap_scoreboard board = new();
   int unsigned cycles = 0;
   bit rsp_stall_on = 1;

   initial begin
      req.valid = 0;
      req.cmd = CMD_NONE;
      req.back_link = '0;
      req.dfa_state = '0;
      req.symbol = '0;
      req.weight_scale = '0;
      req.hit_count = '0;
      req.node_link = '0;
      rsp.ready = 0;
      csr.valid = 0;
      csr.data = '0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 3000000) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // result side: random stall per transaction, then sample on the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp.valid && rsp.ready) begin
            board.check_response('{status_type'(rsp.status), rsp.out_back_link,
                                   rsp.out_dfa_state, rsp.out_symbol, rsp.out_weight_scale,
                                   rsp.out_hit_count, rsp.out_node_link, rsp.occupancy});
         end
      end
   end

   initial begin : rsp_side
      int gap;
      @(negedge reset);
      forever begin
         gap = rsp_stall_on ? $urandom_range(0, 13) : 0;
         if (gap > 0) begin
            rsp.ready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp.ready <= 1;
         do @(posedge clock); while (!rsp.valid);
      end
   end

   bit idle_on = 1;

   // valid stays up after a transaction until the next idle gap or a drain
   task automatic send(cmd_type c, logic [16:0] bl, logic [15:0] ds, logic [7:0] sy,
                       logic [31:0] sc, logic [31:0] hc, logic [31:0] nl);
      int gap;
      gap = idle_on ? $urandom_range(0, 13) : 0;
      if (gap > 0) begin
         req.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1;
      req.cmd <= c;
      req.back_link <= bl;
      req.dfa_state <= ds;
      req.symbol <= sy;
      req.weight_scale <= sc;
      req.hit_count <= hc;
      req.node_link <= nl;
      do @(posedge clock); while (!req.ready);
      board.note_request(c, bl, ds, sy, sc, hc, nl);
   endtask

   task automatic send_random_push(bit narrow);
      logic [31:0] sc, hc;
      sc = narrow ? $urandom_range(0, 3) : $urandom;
      hc = narrow ? $urandom_range(0, 3) : $urandom;
      send(CMD_PUSH, 17'($urandom), 16'($urandom), 8'($urandom), sc, hc, $urandom);
   endtask

   task automatic drain();
      req.valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_capacity(logic [10:0] v);
      drain();
      csr.valid <= 1;
      csr.data <= v;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 0;
      board.set_capacity(v);
   endtask

   task automatic random_phase(int n, int push_bias);
      int r;
      bit narrow;
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(0, 99);
         narrow = ($urandom_range(0, 2) == 0);
         if (r < push_bias) send_random_push(narrow);
         else if (r < 96) send(CMD_POP, 17'($urandom), 16'($urandom), 8'($urandom),
                               $urandom, $urandom, $urandom);
         else if (r < 98) send(CMD_CLEAR, 17'($urandom), 16'($urandom), 8'($urandom),
                               $urandom, $urandom, $urandom);
         else send(CMD_NONE, 17'($urandom), 16'($urandom), 8'($urandom),
                   $urandom, $urandom, $urandom);
      end
   endtask

   initial begin : stim
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: empty pop, field extremes, equal priorities, unused command, clear
      send(CMD_POP, '0, '0, '0, '0, '0, '0);
      send(CMD_PUSH, 17'h1FFFF, 16'hFFFF, 8'hFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
      send(CMD_PUSH, 17'h0FFFF, 16'h0, 8'h0, 32'h0, 32'h0, 32'h0);
      send(CMD_PUSH, 17'h1, 16'h1, 8'h1, 32'h2, 32'h3, 32'h1);
      send(CMD_PUSH, 17'h2, 16'h2, 8'h2, 32'h3, 32'h2, 32'h2);
      send(CMD_PUSH, 17'h3, 16'h3, 8'h3, 32'h6, 32'h1, 32'h3);
      send(CMD_PUSH, 17'h4, 16'h4, 8'h4, 32'h1, 32'h6, 32'h4);
      send(CMD_NONE, 17'h1FFFF, 16'hFFFF, 8'hFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
      repeat (7) send(CMD_POP, '0, '0, '0, '0, '0, '0);
      send(CMD_PUSH, 17'h5, 16'h5, 8'h5, 32'h40000000, 32'h7, 32'h5);
      send(CMD_CLEAR, '0, '0, '0, '0, '0, '0);
      send(CMD_POP, '0, '0, '0, '0, '0, '0);
      // capacity extremes: zero, one, then lowered below occupancy
      write_capacity(11'd0);
      send_random_push(0);
      write_capacity(11'd1);
      send_random_push(0);
      send_random_push(0);
      send(CMD_POP, '0, '0, '0, '0, '0, '0);
      write_capacity(11'd2047);
      random_phase(120, 70);
      write_capacity(11'd5);
      random_phase(80, 50);
      write_capacity(11'd1);
      random_phase(30, 50);
      idle_on = 0;
      rsp_stall_on = 0;
      write_capacity(11'd1024);
      // fill to the top without idling or result stalls, then push once more
      while (board.held() < 1024) send_random_push($urandom_range(0, 1));
      send_random_push(0);
      idle_on = 1;
      rsp_stall_on = 1;
      random_phase(150, 45);
      write_capacity(11'd17);
      random_phase(100, 55);
      write_capacity(11'd1024);
      random_phase(100, 60);
      drain();
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
